@@ rtl/sss_pkg.sv @@
// Shared types and constants for the streaming substring search block.
// Depends on nothing; every file but sss_stream_if imports it.
`default_nettype none

package sss_pkg;

    // Configuration port geometry: five 64-bit registers at 8-byte strides.
    localparam int unsigned APB_DATA_W   = 64;
    localparam int unsigned APB_ADDR_W   = 6;
    localparam int unsigned REG_IDX_LSB  = 3;
    localparam int unsigned REG_IDX_W    = 3;
    localparam int unsigned LEN_REG_W    = 6;

    // The needle words hold a fixed 32 bytes.
    localparam int unsigned NEEDLE_BYTES = 32;
    localparam int unsigned NEEDLE_BITS  = NEEDLE_BYTES * 8;
    localparam int unsigned NEEDLE_IDX_W = 7;
    localparam int unsigned OFFSET_W     = 16;

    typedef logic [7:0] t_byte;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LENGTH = 3'd0,
        REG_WORD_A = 3'd1,
        REG_WORD_B = 3'd2,
        REG_WORD_C = 3'd3,
        REG_WORD_D = 3'd4
    } t_reg_addr;

    // One input beat: a buffer byte and its end-of-buffer mark.
    typedef struct packed {
        t_byte data_byte;
        logic  is_last;
    } t_in_beat;

    // One result beat, given at the end of each buffer.
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
        logic                overflow;
    } t_out_beat;

    // Byte j of the packed needle; bytes past the held 32 read as zero.
    function automatic t_byte needle_byte(input logic [NEEDLE_BITS-1:0] needle,
                                          input logic [NEEDLE_IDX_W-1:0] idx);
        t_byte b;
        if (idx[NEEDLE_IDX_W-1:5] != '0) begin
            b = '0;
        end else begin
            b = needle[idx[4:0]*8 +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sss_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat per transfer.
// Payload type comes from sss_pkg at the instantiation site.
`default_nettype none

interface sss_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/sss_cfg_regs.sv @@
// APB-style register file for the needle, plus the registered needle
// aligned to the window (byte k of the window faces needle byte len-1-k).
// Depends on sss_pkg.
`default_nettype none

module sss_cfg_regs
    import sss_pkg::*;
#(
    parameter int unsigned NEEDLE_MAX = 32,
    localparam int unsigned LW = $clog2(NEEDLE_MAX + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [LW-1:0]         o_len,
    output t_byte                      o_needle [NEEDLE_MAX],
    output logic      [NEEDLE_MAX-1:0] o_mask
);

    logic [LEN_REG_W-1:0]  r_len;
    logic [APB_DATA_W-1:0] r_word [4];
    t_reg_addr             reg_sel;
    logic                  wr_en;

    logic [LW-1:0]         r_len_eff;
    t_byte                 r_aligned [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] r_mask;
    logic [LW-1:0]         n_len_eff;
    t_byte                 n_aligned [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] n_mask;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_addr'(paddr[REG_IDX_LSB +: REG_IDX_W]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int w = 0; w < 4; w++) begin
                r_word[w] <= '0;
            end
        end else if (wr_en) begin
            case (reg_sel)
                REG_LENGTH: r_len     <= pwdata[LEN_REG_W-1:0];
                REG_WORD_A: r_word[0] <= pwdata;
                REG_WORD_B: r_word[1] <= pwdata;
                REG_WORD_C: r_word[2] <= pwdata;
                REG_WORD_D: r_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_sel)
            REG_LENGTH: prdata = APB_DATA_W'(r_len);
            REG_WORD_A: prdata = r_word[0];
            REG_WORD_B: prdata = r_word[1];
            REG_WORD_C: prdata = r_word[2];
            REG_WORD_D: prdata = r_word[3];
            default:    prdata = '0;
        endcase
    end

    // Clamp the length and lay the needle out in window order.
    always_comb begin
        logic [NEEDLE_IDX_W-1:0] len7;
        logic [NEEDLE_IDX_W-1:0] idx;
        logic [NEEDLE_BITS-1:0]  needle;
        needle = {r_word[3], r_word[2], r_word[1], r_word[0]};
        if ({1'b0, r_len} > NEEDLE_IDX_W'(NEEDLE_MAX)) begin
            len7 = NEEDLE_IDX_W'(NEEDLE_MAX);
        end else begin
            len7 = {1'b0, r_len};
        end
        n_len_eff = LW'(len7);
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            n_mask[k] = NEEDLE_IDX_W'(k) < len7;
            idx       = len7 - NEEDLE_IDX_W'(k) - NEEDLE_IDX_W'(1);
            n_aligned[k] = n_mask[k] ? needle_byte(needle, idx) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_eff <= '0;
            r_mask    <= '0;
        end else begin
            r_len_eff <= n_len_eff;
            r_mask    <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_aligned <= n_aligned;
    end

    assign o_len    = r_len_eff;
    assign o_needle = r_aligned;
    assign o_mask   = r_mask;

endmodule

`default_nettype wire

@@ rtl/substring_search_stream_top.sv @@
// Streaming first-occurrence substring search, top level.
// Depends on sss_pkg, sss_stream_if and sss_cfg_regs.
//
//   Port group   Dir    Beat / transfer             Accepted when
//   i_in         sink   data_byte, is_last          i_in.valid && i_in.ready
//   o_res        source found, match_offset, overflow o_res.valid && o_res.ready
//   APB          slave  needle_length, needle words psel && penable && pwrite
//
// One byte is taken every cycle while no last byte waits on an unread result.
// A byte is held in the input register and compared against the whole window;
// the buffer result enters the output register as the last byte moves on.
// i_rst_n is synchronous, active low, and needs no clearing pass.
// A stalled result holds only the last byte of the next buffer; other bytes
// keep flowing while the result waits.
`default_nettype none

module substring_search_stream_top
    import sss_pkg::*;
#(
    parameter int unsigned      NEEDLE_MAX = 32,
    parameter longint unsigned  BUFFER_MAX = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    sss_stream_if.sink                 i_in,
    sss_stream_if.source               o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int unsigned LW = $clog2(NEEDLE_MAX + 1);
    localparam int unsigned PW = $clog2(BUFFER_MAX + 2);
    localparam int unsigned CW = (PW > OFFSET_W) ? PW : OFFSET_W;
    localparam logic [PW-1:0] POS_LIMIT = PW'(BUFFER_MAX);
    localparam logic [PW-1:0] POS_SAT   = PW'(BUFFER_MAX + 1);

    // Needle as the window sees it.
    logic [LW-1:0]         len;
    t_byte                 needle [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] mask;

    sss_cfg_regs #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_len    (len),
        .o_needle (needle),
        .o_mask   (mask)
    );

    // Input register.
    logic     r_s1_valid;
    t_in_beat r_s1;
    logic     s1_adv;
    logic     in_fire;

    // Search state.
    t_byte               r_win [NEEDLE_MAX];
    t_byte               n_win [NEEDLE_MAX];
    logic [PW-1:0]       r_pos;
    logic [PW-1:0]       n_pos;
    logic                r_seen;
    logic [OFFSET_W-1:0] r_off;
    logic                in_range;
    logic                win_eq;
    logic                hit;
    logic [OFFSET_W-1:0] hit_off;
    logic                seen_fin;
    logic [OFFSET_W-1:0] off_fin;

    // Output register.
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    // A byte that ends no buffer always moves on; a last byte needs the
    // output register free or draining.
    assign s1_adv     = r_s1_valid && (!r_s1.is_last || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in.payload;
        end
    end

    // Window after the new byte is shifted in, and its compare.
    always_comb begin
        n_win[0] = r_s1.data_byte;
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
        win_eq = 1'b1;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            if (mask[k] && (n_win[k] != needle[k])) begin
                win_eq = 1'b0;
            end
        end
    end

    // Position, match latch and result fields.
    always_comb begin
        in_range = r_pos < POS_LIMIT;
        n_pos    = in_range ? r_pos + PW'(1) : POS_SAT;
        hit_off  = OFFSET_W'(CW'(n_pos) - CW'(len));
        hit      = in_range && (len != '0) && !r_seen && (CW'(n_pos) >= CW'(len)) && win_eq;
        seen_fin = r_seen || hit;
        off_fin  = hit ? hit_off : r_off;

        n_out.overflow = n_pos == POS_SAT;
        if (len == '0) begin
            n_out.found        = 1'b1;
            n_out.match_offset = '0;
        end else begin
            n_out.found        = seen_fin;
            n_out.match_offset = seen_fin ? off_fin : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1.is_last) begin
                r_pos  <= '0;
                r_seen <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_seen <= seen_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_off <= r_s1.is_last ? '0 : off_fin;
            if (in_range) begin
                r_win <= n_win;
            end
        end
    end

    // Result register: loaded at each last byte, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1.is_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.is_last) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // A result that reports no match carries a zero offset.
    a_no_match_zero_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.match_offset == '0))
        else $error("result without match has nonzero offset");

    // The byte count never passes its saturation value.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte position beyond saturation");

    // Ending a buffer clears the search state and presents a result.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1.is_last) |=> (r_pos == '0) && !r_seen && r_out_valid)
        else $error("search state not cleared at end of buffer");

    // A latched match always lies behind at least one counted byte.
    a_seen_has_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_pos != '0))
        else $error("match latched with empty position");

    // A last byte is never lost while an unread result blocks it.
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.is_last && r_out_valid && !o_res.ready) |=> r_s1_valid)
        else $error("last byte dropped while result stalled");

endmodule

`default_nettype wire

@@ tb/sss_search_checker.sv @@
// Scoreboard for the streaming substring search: tracks register writes and
// input beats, predicts each buffer result, and compares the result beats.
// Depends on sss_pkg.
module sss_search_checker
    import sss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  t_in_beat                   i_in_beat,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    input  t_out_beat                  i_res_beat,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int unsigned WINDOW_BYTES = 32;
    localparam int unsigned POS_LIMIT    = 65536;
    localparam int unsigned REPORT_MAX   = 10;

    // Shadow copy of the needle registers and the search state of one buffer.
    logic [LEN_REG_W-1:0]   needle_len_q;
    logic [NEEDLE_BITS-1:0] needle_q;
    t_byte                  window_q [WINDOW_BYTES];
    int unsigned            position_q;
    logic                   hit_q;
    int unsigned            hit_offset_q;
    t_out_beat              expected_results [$];
    int                     mismatch_count = 0;
    int                     pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    // Start a new buffer: empty window, position zero, nothing latched.
    task automatic clear_search();
        foreach (window_q[k]) window_q[k] = '0;
        position_q   = 0;
        hit_q        = 1'b0;
        hit_offset_q = 0;
    endtask

    task automatic note_mismatch(input string what, input t_out_beat want,
                                 input t_out_beat got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: %s: expected found=%0b offset=%0d overflow=%0b,",
                     $time, what, want.found, want.match_offset, want.overflow);
            $display("    got found=%0b offset=%0d overflow=%0b",
                     got.found, got.match_offset, got.overflow);
        end
    endtask

    // Shift one byte into the window and look for the needle ending at it.
    // Bytes past the position limit are not searched; they only mark overflow.
    task automatic advance_search(input t_in_beat beat);
        int unsigned len;
        int unsigned k;
        int unsigned j;
        logic        same;
        t_out_beat   res;
        len = (needle_len_q > LEN_REG_W'(WINDOW_BYTES)) ? WINDOW_BYTES : int'(needle_len_q);
        if (position_q < POS_LIMIT) begin
            for (k = WINDOW_BYTES - 1; k > 0; k--) window_q[k] = window_q[k-1];
            window_q[0] = beat.data_byte;
            position_q++;
            if (len != 0 && !hit_q && position_q >= len) begin
                same = 1'b1;
                for (j = 0; j < len; j++) begin
                    if (window_q[len-1-j] != needle_q[j*8 +: 8]) same = 1'b0;
                end
                if (same) begin
                    hit_q        = 1'b1;
                    hit_offset_q = position_q - len;
                end
            end
        end else begin
            position_q = POS_LIMIT + 1;
        end

        // The last byte closes the buffer with exactly one result.
        if (beat.is_last) begin
            res.found        = (len == 0) ? 1'b1 : hit_q;
            res.match_offset = (len != 0 && hit_q) ? OFFSET_W'(hit_offset_q) : '0;
            res.overflow     = (position_q > POS_LIMIT);
            expected_results.push_back(res);
            clear_search();
        end
    endtask

    task automatic check_result(input t_out_beat got);
        t_out_beat want;
        if (expected_results.size() == 0) begin
            note_mismatch("result beat with no buffer outstanding", '0, got);
        end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found || got.match_offset !== want.match_offset
                    || got.overflow !== want.overflow) begin
                note_mismatch("result beat mismatch", want, got);
            end
        end
    endtask

    task automatic apply_write(input logic [APB_ADDR_W-1:0] addr,
                               input logic [APB_DATA_W-1:0] data);
        case (t_reg_addr'(addr[REG_IDX_LSB +: REG_IDX_W]))
            REG_LENGTH: needle_len_q = data[LEN_REG_W-1:0];
            REG_WORD_A: needle_q[0 +: 64]   = data;
            REG_WORD_B: needle_q[64 +: 64]  = data;
            REG_WORD_C: needle_q[128 +: 64] = data;
            REG_WORD_D: needle_q[192 +: 64] = data;
            default: ;
        endcase
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            needle_len_q = '0;
            needle_q     = '0;
            clear_search();
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result(i_res_beat);
            if (i_in_valid && i_in_ready) advance_search(i_in_beat);
            if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
        end
        pending_count = expected_results.size();
    end

endmodule

@@ tb/tb_substring_search_stream_top.sv @@
// Testbench top for substring_search_stream_top: drives byte buffers and
// needle settings, applies stalls, and reports the verdict.
// Depends on sss_pkg, sss_stream_if, the block and sss_search_checker.
module tb_substring_search_stream_top;
    import sss_pkg::*;

    localparam int unsigned GAP_PCT          = 17;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_BYTES     = 1200;
    localparam int unsigned SETTLE_CYCLES    = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sss_stream_if #(.T(t_in_beat))  in_ch ();
    sss_stream_if #(.T(t_out_beat)) res_ch ();

    int          mismatches;
    int          pending;
    bit          in_gaps_on;
    bit          res_gaps_on;
    bit          long_hold_req;
    bit          long_hold_done;
    int unsigned buffers_sent;
    int unsigned bytes_sent;
    int unsigned settings_used;
    t_byte       cur_needle [NEEDLE_BYTES];

    substring_search_stream_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sss_search_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_beat    (in_ch.payload),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_beat   (res_ch.payload),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that backs up the input.
    initial begin
        res_ch.ready   = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_done = 1'b1;
            end
            res_ch.ready <= res_gaps_on ? ($urandom_range(0, 99) >= GAP_PCT) : 1'b1;
        end
    end

    // Offer one beat from a falling edge and return at the falling edge after
    // it is taken, with valid still high.
    task automatic push_byte(input t_in_beat beat);
        while (in_gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= beat;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_buffer(input t_byte bytes [$]);
        t_in_beat    beat;
        int unsigned k;
        for (k = 0; k < bytes.size(); k++) begin
            beat.data_byte = bytes[k];
            beat.is_last   = (k == bytes.size() - 1);
            push_byte(beat);
        end
        buffers_sent++;
        bytes_sent += bytes.size();
    endtask

    // Wait until every result is back, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_addr idx, input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) << REG_IDX_LSB);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Load the length and all four needle words from cur_needle while idle.
    // Upper bits of the length write are random; only six bits are kept.
    task automatic set_needle(input logic [LEN_REG_W-1:0] len);
        logic [63:0] word;
        int unsigned w;
        int unsigned j;
        drain();
        word = {$urandom, $urandom};
        word[LEN_REG_W-1:0] = len;
        write_reg(REG_LENGTH, word);
        for (w = 0; w < 4; w++) begin
            for (j = 0; j < 8; j++) word[j*8 +: 8] = cur_needle[w*8 + j];
            write_reg(t_reg_addr'(int'(REG_WORD_A) + w), word);
        end
        settings_used++;
    endtask

    initial begin
        t_byte                buf_q [$];
        t_byte                alpha0;
        t_byte                alpha1;
        logic [LEN_REG_W-1:0] new_len;
        int unsigned          phase;
        int unsigned          first_random;
        int unsigned          n_bufs;
        int unsigned          blen;
        int unsigned          eff;
        int unsigned          at;
        int unsigned          pick;
        int unsigned          j;
        bit                   noisy;
        bit                   wild;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        in_gaps_on    = 1'b1;
        res_gaps_on   = 1'b1;
        long_hold_req = 1'b0;
        buffers_sent  = 0;
        bytes_sent    = 0;
        settings_used = 0;
        foreach (cur_needle[k]) cur_needle[k] = 8'h00;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty needle out of reset: every buffer matches at offset zero.
        buf_q = {8'h00, 8'hFF};
        send_buffer(buf_q);

        // Three-byte needle found one byte in, then buffers shorter than it.
        cur_needle[0] = 8'h5A;
        cur_needle[1] = 8'h00;
        cur_needle[2] = 8'hFF;
        set_needle(LEN_REG_W'(3));
        buf_q = {8'h11, 8'h5A, 8'h00, 8'hFF};
        send_buffer(buf_q);
        buf_q = {8'h5A, 8'h00};
        send_buffer(buf_q);
        buf_q = {8'hFF};
        send_buffer(buf_q);

        // One-byte needle matching only at the last byte; then an empty needle
        // whose words are all ones.
        foreach (cur_needle[k]) cur_needle[k] = 8'hFF;
        set_needle(LEN_REG_W'(1));
        buf_q = {8'h00, 8'h00, 8'hFF};
        send_buffer(buf_q);
        set_needle('0);
        buf_q = {8'h5A};
        send_buffer(buf_q);

        // Random phases: a new needle each phase, then a handful of buffers
        // built around it so that full and partial matches are common.
        phase        = 0;
        first_random = bytes_sent;
        while (bytes_sent - first_random < RANDOM_BYTES) begin
            alpha0 = t_byte'($urandom);
            alpha1 = t_byte'($urandom);
            wild   = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 99);
            if (phase == 0) begin
                new_len = LEN_REG_W'(32);
                alpha0  = 8'hFF;
                alpha1  = 8'hFE;
            end else if (phase == 1) begin
                new_len = '1;
                alpha0  = 8'h00;
            end else if (phase == 2 || pick < 5) begin
                new_len = '0;
            end else if (pick < 70) begin
                new_len = LEN_REG_W'($urandom_range(1, 6));
            end else if (pick < 85) begin
                new_len = LEN_REG_W'($urandom_range(7, 16));
            end else if (pick < 95) begin
                new_len = LEN_REG_W'($urandom_range(17, 32));
            end else begin
                new_len = LEN_REG_W'($urandom_range(33, 63));
            end
            foreach (cur_needle[k]) begin
                if (phase == 0) cur_needle[k] = 8'hFF;
                else if (phase == 1) cur_needle[k] = 8'h00;
                else if (wild) cur_needle[k] = t_byte'($urandom);
                else cur_needle[k] = $urandom_range(0, 1) ? alpha1 : alpha0;
            end
            set_needle(new_len);

            // Phases five and six run without any idling; phase three holds
            // the result side off while short buffers keep coming.
            in_gaps_on    = !(phase == 5 || phase == 6);
            res_gaps_on   = in_gaps_on;
            long_hold_req = (phase == 3);
            eff           = (new_len > LEN_REG_W'(32)) ? 32 : int'(new_len);
            n_bufs        = (phase == 3) ? 20 : $urandom_range(3, 8);

            repeat (n_bufs) begin
                if (phase == 3) blen = $urandom_range(2, 4);
                else blen = $urandom_range((eff > 3) ? eff - 3 : 1, eff + 10);
                noisy = ($urandom_range(0, 99) < 15);
                buf_q.delete();
                repeat (blen) begin
                    if (noisy || $urandom_range(0, 3) == 0) buf_q.push_back(t_byte'($urandom));
                    else buf_q.push_back($urandom_range(0, 1) ? alpha1 : alpha0);
                end
                // Plant one or two needle copies; some get a corrupted last byte.
                if (!noisy && eff != 0 && eff <= blen && $urandom_range(0, 99) < 75) begin
                    repeat ($urandom_range(1, 2)) begin
                        at = $urandom_range(0, blen - eff);
                        for (j = 0; j < eff; j++) buf_q[at+j] = cur_needle[j];
                        if ($urandom_range(0, 9) == 0) buf_q[at+eff-1] ^= 8'h01;
                    end
                end
                send_buffer(buf_q);
            end
            phase++;
        end

        drain();
        $display("Run covered %0d buffers, %0d bytes and %0d needle settings,",
                 buffers_sent, bytes_sent, settings_used);
        $display("with random stalls, a %0d-cycle result hold-off and stretches without idling.",
                 LONG_HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
